// ===== design/ple_pkg.sv =====
// Shared constants and types for the positional list engine.
package ple_pkg;

	localparam int PLE_CAPACITY = 16;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FIND     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	// per-cell control
	typedef struct packed {
		logic load;       // take the new value
		logic take_left;  // take the lower neighbor (insert shift)
		logic take_right; // take the upper neighbor (remove shift)
		logic live;       // cell holds a valid entry
	} ple_cell_ctl_t;

endpackage

// ===== design/positional_list_engine_core.sv =====
// Top level of the positional list engine: cell chain, request decode and result register.
// Ordered list of up to CAPACITY signed 32-bit values addressed by 1-based position. Each
// request (insert, remove, read, find, contains) is served in the cycle it is taken: every
// list slot is a cell that shifts toward or away from its neighbors and compares its entry
// against the key in the same cycle, so a new request is taken every cycle while the result
// register is free or being drained. Each request gives exactly one result transfer carrying
// the read value, the first match position, the found flag, the entry count and a status code
// (0 ok, 1 bad position, 2 full, 3 empty). Position is 5 bits, so only the first 31 slots are
// addressable; entry_count and result_position are reported modulo 32.
module positional_list_engine_core import ple_pkg::*; #(
	parameter int CAPACITY = PLE_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // func[2:0], position[7:3], element_value[39:8]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // result_value[31:0], result_position[36:32],
	                                       // found[37], entry_count[42:38], status[44:43]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  element_value;

	assign func          = s_tdata[2:0];
	assign position      = s_tdata[7:3];
	assign element_value = s_tdata[39:8];

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic             in_fire;

	assign cnt_x   = CMP_W'(count_q);
	assign pos_x   = CMP_W'(position);
	assign s_tready = !m_tvalid || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	logic is_ins, is_rem, is_read, is_find, is_cont;
	logic ins_bad, rem_bad, cnt_zero, is_full;
	logic ins_ok, rem_ok;

	assign is_ins   = (func == FUNC_INSERT);
	assign is_rem   = (func == FUNC_REMOVE);
	assign is_read  = (func == FUNC_READ);
	assign is_find  = (func == FUNC_FIND);
	assign is_cont  = (func == FUNC_CONTAINS);
	assign cnt_zero = (count_q == '0);
	assign is_full  = (cnt_x >= CMP_W'(CAPACITY));
	assign ins_bad  = (position == '0) || (pos_x > cnt_x + CMP_W'(1));
	assign rem_bad  = (position == '0) || (pos_x > cnt_x);
	assign ins_ok   = is_ins && !ins_bad && !is_full;
	assign rem_ok   = is_rem && !cnt_zero && !rem_bad;

	// cell chain
	ple_cell_ctl_t    ctl   [CAPACITY];
	logic [VAL_W-1:0] cval  [CAPACITY];
	logic [CAPACITY-1:0] match;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cval[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cval[i+1];
		end

		always_comb begin
			ctl[i].load       = in_fire && ins_ok && (pos_x == CMP_W'(i + 1));
			ctl[i].take_left  = in_fire && ins_ok && (pos_x < CMP_W'(i + 1));
			ctl[i].take_right = in_fire && rem_ok && (pos_x <= CMP_W'(i + 1));
			ctl[i].live       = (CMP_W'(i) < cnt_x);
		end

		ple_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.new_val  (element_value),
			.left_val (left_v),
			.right_val(right_v),
			.val      (cval[i]),
			.match    (match[i])
		);
	end

	// read select and first-match search
	logic [VAL_W-1:0] rd_val;
	logic [CMP_W-1:0] first_x;
	logic             any_match;

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_x == CMP_W'(i + 1)) begin
				rd_val = rd_val | cval[i];
			end
		end
	end

	always_comb begin
		first_x = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				first_x = CMP_W'(i);
			end
		end
	end

	assign any_match = |match;

	// result assembly
	logic [CMP_W-1:0]    cnt_next_x;
	logic [VAL_W-1:0]    r_value;
	logic [POS_W-1:0]    r_pos;
	logic                r_found;
	logic [STATUS_W-1:0] r_status;

	always_comb begin
		cnt_next_x = cnt_x;
		r_value    = '0;
		r_pos      = '0;
		r_found    = 1'b0;
		r_status   = ST_OK;
		if (is_ins) begin
			if (ins_bad) begin
				r_status = ST_BADPOS;
			end else if (is_full) begin
				r_status = ST_FULL;
			end else begin
				cnt_next_x = cnt_x + CMP_W'(1);
			end
		end else if (is_rem || is_read) begin
			if (cnt_zero) begin
				r_status = ST_EMPTY;
			end else if (rem_bad) begin
				r_status = ST_BADPOS;
			end else if (is_rem) begin
				cnt_next_x = cnt_x - CMP_W'(1);
			end else begin
				r_value = rd_val;
			end
		end else if (is_find) begin
			if (cnt_zero) begin
				r_status = ST_EMPTY;
			end else if (any_match) begin
				r_found = 1'b1;
				r_pos   = POS_W'(first_x + CMP_W'(1));
			end
		end else if (is_cont) begin
			r_found = any_match;
		end
	end

	logic [M_TDATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q  <= CNT_W'(cnt_next_x);
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= {3'b000, r_status, cnt_next_x[POS_W-1:0], r_found, r_pos, r_value};
		end
	end

	assign m_tdata = out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && rem_ok |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not shrink the list");

	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[37] |-> m_tdata[36:32] == '0)
		else $error("match position without a match");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_ins && !ins_bad && is_full |=> count_q == $past(count_q))
		else $error("full list changed on insert");
`endif

endmodule

// ===== design/ple_cell.sv =====
// One list slot: holds an entry, shifts to or from its neighbors, compares against the key.
module ple_cell import ple_pkg::*; (
	input  logic               clk,
	input  ple_cell_ctl_t      ctl,
	input  logic [VAL_W-1:0]   new_val,
	input  logic [VAL_W-1:0]   left_val,
	input  logic [VAL_W-1:0]   right_val,
	output logic [VAL_W-1:0]   val,
	output logic               match
);

	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= new_val;
		end else if (ctl.take_left) begin
			val_q <= left_val;
		end else if (ctl.take_right) begin
			val_q <= right_val;
		end
	end

	assign val   = val_q;
	assign match = ctl.live && (val_q == new_val);

endmodule
